// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- sv/rvde_pkg.sv -----
// ----------------------------------------------------------------------------
// rvde_pkg
// Opcodes, result types and shared constants of the RV32I execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package rvde_pkg;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] F7_ZERO   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

  // Depth of the result queue; pointers are two bits wide.
  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_kind_e;

  // Outcome of decoding and executing one instruction.
  typedef struct packed {
    logic [31:0] next;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    mem_kind_e   kind;
    logic [31:0] maddr;
    logic [31:0] sval;
    logic [2:0]  f3;
    logic        bad;
  } exe_t;

  // One finished result beat.
  typedef struct packed {
    logic [31:0] instr_address;
    logic [31:0] next_address;
    logic        dest_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    mem_kind_e   mem_kind;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic        undecoded;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/rvde_ram.sv -----
// ----------------------------------------------------------------------------
// rvde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rvde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/rvde_alu.sv -----
// ----------------------------------------------------------------------------
// rvde_alu
// Combinational decode and execute of one RV32I instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module rvde_alu
  import rvde_pkg::*;
(
  input  wire logic [31:0] instr_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] rs1_i,
  input  wire logic [31:0] rs2_i,
  output      exe_t        exe_o
);

  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, sum_i;
  logic [4:0]  sh;
  logic        take;
  exe_t        e;

  assign op    = instr_i[6:0];
  assign f3    = instr_i[14:12];
  assign f7    = instr_i[31:25];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign pc4   = pc_i + 32'd4;
  assign sum_i = rs1_i + imm_i;
  assign sh    = rs2_i[4:0];

  always_comb begin
    e       = '0;
    e.next  = pc4;
    e.rd    = instr_i[11:7];
    e.f3    = f3;
    e.kind  = MEM_NONE;
    take    = 1'b0;
    unique case (op)
      OP_LOAD: begin
        e.maddr = sum_i;
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
          e.bad = 1'b1;
        end else begin
          e.wr   = 1'b1;
          e.kind = MEM_LOAD;
        end
      end
      OP_STORE: begin
        e.maddr = rs1_i + imm_s;
        if (f3[2] || f3 == 3'd3) begin
          e.bad = 1'b1;
        end else begin
          e.kind = MEM_STORE;
          unique case (f3[1:0])
            2'd0:    e.sval = {24'd0, rs2_i[7:0]};
            2'd1:    e.sval = {16'd0, rs2_i[15:0]};
            default: e.sval = rs2_i;
          endcase
        end
      end
      OP_IMM: begin
        e.wr = 1'b1;
        unique case (f3)
          3'd0:    e.val = sum_i;
          3'd2:    e.val = {31'd0, $signed(rs1_i) < $signed(imm_i)};
          3'd3:    e.val = {31'd0, rs1_i < imm_i};
          3'd4:    e.val = rs1_i ^ imm_i;
          3'd6:    e.val = rs1_i | imm_i;
          3'd7:    e.val = rs1_i & imm_i;
          default: begin
            e.bad = 1'b1;
            e.wr  = 1'b0;
          end
        endcase
      end
      OP_REG: begin
        e.wr = 1'b1;
        unique case (f3)
          3'd0: begin
            if (f7 == F7_ZERO) begin
              e.val = rs1_i + rs2_i;
            end else if (f7 == F7_ALT) begin
              e.val = rs1_i - rs2_i;
            end else begin
              e.bad = 1'b1;
              e.wr  = 1'b0;
            end
          end
          3'd1: e.val = rs1_i << sh;
          3'd2: e.val = {31'd0, $signed(rs1_i) < $signed(rs2_i)};
          3'd3: e.val = {31'd0, rs1_i < rs2_i};
          3'd4: e.val = rs1_i ^ rs2_i;
          3'd5: begin
            if (f7 == F7_ZERO) begin
              e.val = rs1_i >> sh;
            end else if (f7 == F7_ALT) begin
              e.val = $unsigned($signed(rs1_i) >>> sh);
            end else begin
              e.bad = 1'b1;
              e.wr  = 1'b0;
            end
          end
          3'd6:    e.val = rs1_i | rs2_i;
          default: e.val = rs1_i & rs2_i;
        endcase
      end
      OP_BRANCH: begin
        unique case (f3)
          3'd0:    take = rs1_i == rs2_i;
          3'd1:    take = rs1_i != rs2_i;
          3'd4:    take = $signed(rs1_i) < $signed(rs2_i);
          3'd5:    take = !($signed(rs1_i) < $signed(rs2_i));
          3'd6:    take = rs1_i < rs2_i;
          3'd7:    take = rs1_i >= rs2_i;
          default: e.bad = 1'b1;
        endcase
        if (take) begin
          e.next = pc_i + imm_b;
        end
      end
      OP_JAL: begin
        e.val  = pc4;
        e.wr   = 1'b1;
        e.next = pc_i + imm_j;
      end
      OP_JALR: begin
        e.val  = pc4;
        e.wr   = 1'b1;
        e.next = {sum_i[31:1], 1'b0};
      end
      OP_LUI: begin
        e.val = instr_i & UPPER_MASK;
        e.wr  = 1'b1;
      end
      OP_AUIPC: begin
        e.val = pc_i + (instr_i & UPPER_MASK);
        e.wr  = 1'b1;
      end
      default: e.bad = 1'b1;
    endcase
    if (e.bad) begin
      e.wr   = 1'b0;
      e.kind = MEM_NONE;
      e.sval = '0;
      e.next = pc4;
    end
    if (e.kind == MEM_NONE) begin
      e.maddr = '0;
    end
    if (!e.wr || e.rd == 5'd0) begin
      e.wr  = 1'b0;
      e.rd  = 5'd0;
      e.val = '0;
    end
  end

  assign exe_o = e;

endmodule

`default_nettype wire

// ----- sv/rvde_outq.sv -----
// ----------------------------------------------------------------------------
// rvde_outq
// Small result queue that decouples execution from the output receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module rvde_outq
  import rvde_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire res_t       data_i,
  input  wire logic       pop_i,
  output      logic       valid_o,
  output      res_t       data_o,
  output      logic [2:0] count_o
);

  res_t       buf_q [QDEPTH];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 3'd0;
  assign pop     = pop_i && valid_o;
  assign data_o  = buf_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 2'd1;
      end
      if (pop) begin
        rp_q <= rp_q + 2'd1;
      end
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- sv/rv32i_decode_execute_top.sv -----
// ----------------------------------------------------------------------------
// rv32i_decode_execute_top
// RV32I decode and execute core with a banked data store and result queue.
// ----------------------------------------------------------------------------
// Usage. Instruction words arrive as beats on the s_axis channel, one per
// instruction, in program order; the word must be the one fetched at the
// current program counter, which the block reports back in each result.
// Every instruction yields exactly one result beat on m_axis, in order.
// The cfg channel loads start_address, which also sets the program counter;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. The cfg channel is always ready. A result passes
// the decode/execute stage and the writeback stage into the queue before
// it is visible on m_axis. Throughput: one instruction per cycle while
// s_axis_tready is high. Operand reads go to two copies of the register file
// RAM at acceptance; results of the two previous instructions are forwarded,
// so no interlock is needed. Loads read the four byte banks of the
// data store in the execute stage and are aligned in the writeback stage.
// Reset: the register file is cleared through valid bits at once. The data
// store is cleared by a pass over all DATA_BYTES/4 rows, one row of all four
// banks per cycle, during which s_axis_tready is low. DATA_BYTES must be
// a power of two. When the receiver stalls, the four-entry queue fills and
// s_axis_tready drops once four results are queued or in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rv32i_decode_execute_top
  import rvde_pkg::*;
#(
  parameter int unsigned DATA_BYTES = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // instruction
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,
  // instr_address, next_address, dest_written, dest_reg, dest_value,
  // mem_address, store_value, undecoded, then zero fill
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [167:0] m_axis_tdata,
  // mem_kind
  output      logic [1:0]   m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int unsigned ROWS = DATA_BYTES / 4;
  localparam int unsigned BAW  = $clog2(DATA_BYTES);
  localparam int unsigned RAW  = BAW - 2;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e         state_q, state_d;
  logic [RAW-1:0] clr_q;

  logic        in_fire, cfg_fire;
  logic [31:0] pc_q;
  logic        s1_q, s2_q;
  logic [31:0] s1_instr_q;
  logic [31:0] s1_pc_q;
  exe_t        exe, s2_exe_q;
  logic [31:0] s2_pc_q;
  logic [1:0]  s2_off_q;

  logic [31:0] rf_vld_q;
  logic [31:0] rf_rd1, rf_rd2, rs1v, rs2v;
  logic [4:0]  rs1, rs2;
  logic        rf_we;
  logic [31:0] wb_val;
  logic        fwd_q;
  logic [4:0]  fwd_rd_q;
  logic [31:0] fwd_val_q;

  logic [2:0]  q_count;
  logic [3:0]  inflight;
  res_t        res, q_data;
  logic        q_valid;

  // ---------------------------------------------------------------- control
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign inflight    = {1'b0, q_count} + {3'd0, s1_q} + {3'd0, s2_q};
  assign s_axis_tready = (state_q == ST_RUN) && (inflight < 4'(QDEPTH));
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == RAW'(ROWS - 1)) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + RAW'(1);
      end
    end
  end

  // ------------------------------------------------------------ register file
  // Two RAM copies give two read ports; both take every writeback.
  rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(s2_exe_q.rd), .wdata_i(wb_val),
    .re_i(in_fire), .raddr_i(s_axis_tdata[19:15]), .rdata_o(rf_rd1)
  );
  rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(s2_exe_q.rd), .wdata_i(wb_val),
    .re_i(in_fire), .raddr_i(s_axis_tdata[24:20]), .rdata_o(rf_rd2)
  );

  assign rs1 = s1_instr_q[19:15];
  assign rs2 = s1_instr_q[24:20];

  // The writeback stage and the write taken at the read edge are forwarded;
  // an entry never written since reset reads as zero.
  function automatic logic [31:0] operand(
    input logic [4:0]  idx,
    input logic [31:0] ram,
    input logic        wb_en,
    input logic [4:0]  wb_rd,
    input logic [31:0] wb_v,
    input logic        f_en,
    input logic [4:0]  f_rd,
    input logic [31:0] f_v,
    input logic        vld
  );
    logic [31:0] r;
    priority if (idx == 5'd0)            r = '0;
    else if (wb_en && wb_rd == idx)      r = wb_v;
    else if (f_en && f_rd == idx)        r = f_v;
    else if (vld)                        r = ram;
    else                                 r = '0;
    return r;
  endfunction

  assign rs1v = operand(rs1, rf_rd1, rf_we, s2_exe_q.rd, wb_val,
                        fwd_q, fwd_rd_q, fwd_val_q, rf_vld_q[rs1]);
  assign rs2v = operand(rs2, rf_rd2, rf_we, s2_exe_q.rd, wb_val,
                        fwd_q, fwd_rd_q, fwd_val_q, rf_vld_q[rs2]);

  // ------------------------------------------------------------------ execute
  rvde_alu u_alu (
    .instr_i(s1_instr_q), .pc_i(s1_pc_q), .rs1_i(rs1v), .rs2_i(rs2v), .exe_o(exe)
  );

  // ---------------------------------------------------------------- data store
  logic [RAW-1:0] row, row_inc;
  logic [1:0]     off;
  logic [2:0]     st_len;
  logic [7:0]     bank_rd [4];

  assign row     = exe.maddr[BAW-1:2];
  assign row_inc = row + RAW'(1);
  assign off     = exe.maddr[1:0];
  always_comb begin
    unique case (exe.f3[1:0])
      2'd0:    st_len = 3'd1;
      2'd1:    st_len = 3'd2;
      default: st_len = 3'd4;
    endcase
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]     rel;
    logic [RAW-1:0] brow, waddr;
    logic           we, re;
    logic [7:0]     wdata;

    assign rel   = 2'(k) - off;
    assign brow  = (2'(k) >= off) ? row : row_inc;
    assign re    = s1_q && exe.kind == MEM_LOAD;
    assign we    = (state_q == ST_CLEAR) ||
                   (s1_q && exe.kind == MEM_STORE && {1'b0, rel} < st_len);
    assign waddr = (state_q == ST_CLEAR) ? clr_q : brow;
    assign wdata = (state_q == ST_CLEAR) ? 8'd0 : 8'(exe.sval >> {rel, 3'd0});

    rvde_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
      .re_i(re), .raddr_i(brow), .rdata_o(bank_rd[k])
    );
  end

  // ---------------------------------------------------------------- writeback
  logic [7:0] lb0, lb1, lb2, lb3;
  logic [31:0] ld_val;

  assign lb0 = bank_rd[s2_off_q];
  assign lb1 = bank_rd[s2_off_q + 2'd1];
  assign lb2 = bank_rd[s2_off_q + 2'd2];
  assign lb3 = bank_rd[s2_off_q + 2'd3];

  always_comb begin
    unique case (s2_exe_q.f3)
      3'd0:    ld_val = {{24{lb0[7]}}, lb0};
      3'd1:    ld_val = {{16{lb1[7]}}, lb1, lb0};
      3'd4:    ld_val = {24'd0, lb0};
      3'd5:    ld_val = {16'd0, lb1, lb0};
      default: ld_val = {lb3, lb2, lb1, lb0};
    endcase
  end

  assign wb_val = (s2_exe_q.kind == MEM_LOAD && s2_exe_q.wr) ? ld_val : s2_exe_q.val;
  assign rf_we  = s2_q && s2_exe_q.wr;

  always_comb begin
    res.instr_address = s2_pc_q;
    res.next_address  = s2_exe_q.next;
    res.dest_written  = s2_exe_q.wr;
    res.dest_reg      = s2_exe_q.rd;
    res.dest_value    = wb_val;
    res.mem_kind      = s2_exe_q.kind;
    res.mem_address   = s2_exe_q.maddr;
    res.store_value   = s2_exe_q.sval;
    res.undecoded     = s2_exe_q.bad;
  end

  // ------------------------------------------------------------ pipeline regs
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_instr_q <= s_axis_tdata;
    end
    if (s1_q) begin
      s2_exe_q <= exe;
      s2_pc_q  <= s1_pc_q;
      s2_off_q <= off;
    end
    fwd_rd_q  <= s2_exe_q.rd;
    fwd_val_q <= wb_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
      fwd_q    <= 1'b0;
      pc_q     <= '0;
      s1_pc_q  <= '0;
      rf_vld_q <= '0;
    end else begin
      s1_q  <= in_fire;
      s2_q  <= s1_q;
      fwd_q <= rf_we;
      // The next instruction may be accepted in the cycle its predecessor
      // executes, so the fetch address is taken from the executing one.
      if (in_fire) begin
        s1_pc_q <= s1_q ? exe.next : pc_q;
      end
      if (cfg_fire) begin
        pc_q <= cfg_data_i;
      end else if (s1_q) begin
        pc_q <= exe.next;
      end
      if (rf_we) begin
        rf_vld_q[s2_exe_q.rd] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- result queue
  rvde_outq u_outq (
    .clk_i, .rst_ni, .push_i(s2_q), .data_i(res), .pop_i(m_axis_tready),
    .valid_o(q_valid), .data_o(q_data), .count_o(q_count)
  );

  assign m_axis_tvalid = q_valid;
  assign m_axis_tuser  = q_data.mem_kind;
  assign m_axis_tdata  = {1'b0, q_data.undecoded, q_data.store_value,
                          q_data.mem_address, q_data.dest_value, q_data.dest_reg,
                          q_data.dest_written, q_data.next_address,
                          q_data.instr_address};

  // ---------------------------------------------------------------- assertions
  `ASSERT_IMP(a_no_accept_in_clear, in_fire, state_q == ST_RUN)
  `ASSERT_IMP(a_no_overflow, 1'b1, inflight <= 4'(QDEPTH))
  `ASSERT_NEXT(a_stage_follows, in_fire, s1_q)
  `ASSERT_IMP(a_no_x0_write, rf_we, s2_exe_q.rd != 5'd0)

endmodule

`default_nettype wire

// ----- dv/rv32i_decode_execute_checker.sv -----
// ----------------------------------------------------------------------------
// rv32i_decode_execute_checker
// Watches the instruction, result and start-address channels, predicts each
// retired instruction and compares result beats field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_decode_execute_checker
  import rvde_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [31:0]  s_tdata_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [167:0] m_tdata_i,
  input  wire logic [1:0]   m_tuser_i,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic [31:0]  cfg_data_i,
  output int                errors_o,
  output int                pending_o
);

  logic [31:0] gpr [0:31];
  logic [7:0]  dmem [0:4095];
  logic [31:0] pc_q;
  logic [31:0] start_q;
  res_t        retire_q [$];
  int          errors;

  function automatic logic [31:0] fetch_word(input logic [31:0] addr);
    logic [31:0] w;
    logic [11:0] idx;
    for (int i = 0; i < 4; i++) begin
      idx = addr[11:0] + i[11:0];
      w[8*i +: 8] = dmem[idx];
    end
    return w;
  endfunction

  task automatic execute(input logic [31:0] ins, output res_t r);
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [31:0] a, b, pc, nxt, val, maddr, sval, ld;
    logic [31:0] imm_i, imm_s, imm_b, imm_j;
    logic [4:0]  sh;
    logic [11:0] idx;
    logic        wr, bad, take;
    mem_kind_e   kind;
    op = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    rd = ins[11:7];
    a = gpr[ins[19:15]];
    b = gpr[ins[24:20]];
    pc = pc_q;
    nxt = pc + 32'd4;
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    sh = b[4:0];
    wr = 1'b0; bad = 1'b0; take = 1'b0;
    val = '0; maddr = '0; sval = '0;
    kind = MEM_NONE;
    case (op)
      OP_LOAD: begin
        maddr = a + imm_i;
        ld = fetch_word(maddr);
        case (f3)
          3'd0: val = {{24{ld[7]}}, ld[7:0]};
          3'd1: val = {{16{ld[15]}}, ld[15:0]};
          3'd2: val = ld;
          3'd4: val = {24'd0, ld[7:0]};
          3'd5: val = {16'd0, ld[15:0]};
          default: bad = 1'b1;
        endcase
        if (!bad) begin
          wr = 1'b1;
          kind = MEM_LOAD;
        end
      end
      OP_STORE: begin
        maddr = a + imm_s;
        if (f3 <= 3'd2) begin
          sval = (f3 == 3'd2) ? b : (f3 == 3'd1) ? {16'd0, b[15:0]} : {24'd0, b[7:0]};
          for (int i = 0; i < (1 << f3); i++) begin
            idx = maddr[11:0] + i[11:0];
            dmem[idx] = sval[8*i +: 8];
          end
          kind = MEM_STORE;
        end else begin
          bad = 1'b1;
        end
      end
      OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = a + imm_i;
          3'd2: val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
          3'd3: val = (a < imm_i) ? 32'd1 : 32'd0;
          3'd4: val = a ^ imm_i;
          3'd6: val = a | imm_i;
          3'd7: val = a & imm_i;
          default: bad = 1'b1;
        endcase
      end
      OP_REG: begin
        wr = 1'b1;
        case (f3)
          3'd0: begin
            if (f7 == F7_ZERO) val = a + b;
            else if (f7 == F7_ALT) val = a - b;
            else bad = 1'b1;
          end
          3'd1: val = a << sh;
          3'd2: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          3'd3: val = (a < b) ? 32'd1 : 32'd0;
          3'd4: val = a ^ b;
          3'd5: begin
            if (f7 == F7_ZERO) val = a >> sh;
            else if (f7 == F7_ALT) val = $signed(a) >>> sh;
            else bad = 1'b1;
          end
          3'd6: val = a | b;
          default: val = a & b;
        endcase
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = ($signed(a) < $signed(b));
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: bad = 1'b1;
        endcase
        if (take) nxt = pc + imm_b;
      end
      OP_JAL: begin
        val = pc + 32'd4;
        wr = 1'b1;
        nxt = pc + imm_j;
      end
      OP_JALR: begin
        val = pc + 32'd4;
        wr = 1'b1;
        nxt = (a + imm_i) & ~32'd1;
      end
      OP_LUI: begin
        val = ins & UPPER_MASK;
        wr = 1'b1;
      end
      OP_AUIPC: begin
        val = pc + (ins & UPPER_MASK);
        wr = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    // A NOP leaves everything but the program counter untouched.
    if (bad) begin
      wr = 1'b0; kind = MEM_NONE; sval = '0; nxt = pc + 32'd4;
    end
    if (kind == MEM_NONE) maddr = '0;
    if (wr && rd != 5'd0) begin
      gpr[rd] = val;
    end else begin
      wr = 1'b0; rd = '0; val = '0;
    end
    pc_q = nxt;
    r.instr_address = pc;
    r.next_address  = nxt;
    r.dest_written  = wr;
    r.dest_reg      = rd;
    r.dest_value    = val;
    r.mem_kind      = kind;
    r.mem_address   = maddr;
    r.store_value   = sval;
    r.undecoded     = bad;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < 4096; i++) dmem[i] = '0;
      start_q = '0;
      pc_q = '0;
      retire_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        start_q = cfg_data_i;
        pc_q = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        execute(s_tdata_i, want);
        retire_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.instr_address = m_tdata_i[31:0];
        got.next_address  = m_tdata_i[63:32];
        got.dest_written  = m_tdata_i[64];
        got.dest_reg      = m_tdata_i[69:65];
        got.dest_value    = m_tdata_i[101:70];
        got.mem_address   = m_tdata_i[133:102];
        got.store_value   = m_tdata_i[165:134];
        got.undecoded     = m_tdata_i[166];
        got.mem_kind      = mem_kind_e'(m_tuser_i);
        if (retire_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat at pc %h", got.instr_address);
        end else begin
          want = retire_q.pop_front();
          check_field("instr_address", want.instr_address, got.instr_address);
          check_field("next_address", want.next_address, got.next_address);
          check_field("dest_written", want.dest_written, got.dest_written);
          check_field("dest_reg", want.dest_reg, got.dest_reg);
          check_field("dest_value", want.dest_value, got.dest_value);
          check_field("mem_kind", want.mem_kind, got.mem_kind);
          check_field("mem_address", want.mem_address, got.mem_address);
          check_field("store_value", want.store_value, got.store_value);
          check_field("undecoded", want.undecoded, got.undecoded);
        end
      end
    end
    errors_o <= errors;
    pending_o <= retire_q.size();
  end

endmodule

`default_nettype wire

// ----- dv/rv32i_decode_execute_top_test.sv -----
// ----------------------------------------------------------------------------
// rv32i_decode_execute_top_test
// Drives instruction words and start addresses into the core and lets the
// checker compare every result beat with its own prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_decode_execute_top_test;
  import rvde_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // instr_address, next_address, dest_written, dest_reg, dest_value,
  // mem_address, store_value, undecoded, then zero fill
  logic [167:0] m_axis_tdata;
  // mem_kind
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i = '0;
  int           errors;
  int           pending;
  int           cycles = 0;
  int           sent = 0;

  always #6 clk_i = ~clk_i;

  rv32i_decode_execute_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  rv32i_decode_execute_checker retire_check (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // The watchdog covers the reset clearing pass as well as every stall.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rv32i_decode_execute_top_test: FAIL");
      $finish;
    end
  end

  // Instruction encoders for the R, I, S, B and J formats.
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
      input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // Random instruction, weighted towards well-formed encodings. Memory
  // accesses often use x0 as base so that loads meet earlier stores.
  function automatic logic [31:0] random_instr();
    int unsigned pick;
    logic [4:0]  rs1, rs2, rd;
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [6:0]  f7;
    pick = $urandom_range(0, 99);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    rd = 5'($urandom);
    f3 = 3'($urandom);
    imm = 12'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      rs1 = 5'd0;
      imm = 12'($urandom_range(0, 63));
    end
    case ($urandom_range(0, 3))
      0: f7 = F7_ALT;
      1: f7 = 7'($urandom);
      default: f7 = F7_ZERO;
    endcase
    if (pick < 10) return $urandom;
    if (pick < 30) return enc_i(12'($urandom), rs1, f3, rd, OP_IMM);
    if (pick < 50) return enc_r(f7, rs2, rs1, f3, rd);
    if (pick < 62) return enc_i(imm, rs1, f3, rd, OP_LOAD);
    if (pick < 74) return enc_s(imm, rs2, rs1, f3);
    if (pick < 84) return enc_b(13'($urandom), rs2, rs1, f3);
    if (pick < 88) return enc_j(21'($urandom), rd);
    if (pick < 92) return enc_i(12'($urandom), rs1, f3, rd, OP_JALR);
    if (pick < 96) return {20'($urandom), rd, OP_LUI};
    return {20'($urandom), rd, OP_AUIPC};
  endfunction

  // Sender gap: mostly none or short, now and then long. Inside the burst
  // window no gaps are left at all.
  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (sent >= 120 && sent < 180) return 0;
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one instruction beat and returns at the falling edge after it
  // has been taken. Called at a falling edge.
  task automatic send_instr(input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  // Waits until every predicted result has come back and the pipeline has
  // drained, then loads a new start address.
  task automatic load_start(input logic [31:0] addr);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls of mixed length, no stalls during the sender's
  // burst window, and one long hold-off in the middle of the random part
  // that fills the result queue and stalls the input side.
  initial begin
    int stall_left;
    int hold_left;
    bit held;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sent >= 300) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sent >= 120 && sent < 180) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
          end
          3: begin
            stall_left = $urandom_range(10, 30);
            m_axis_tready <= 1'b0;
          end
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The data store clearing pass holds s_axis_tready low; the first
    // start address is loaded once the block is ready for work.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    load_start(32'h0000_0000);

    // Directed part: operand extremes, a range of operations and the NOP cases.
    send_instr({20'hFFFFF, 5'd1, OP_LUI});
    send_instr(enc_i(12'h7FF, 5'd1, 3'd0, 5'd1, OP_IMM));
    send_instr(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM));
    send_instr(enc_r(F7_ZERO, 5'd2, 5'd1, 3'd0, 5'd3));
    send_instr(enc_r(F7_ALT, 5'd1, 5'd2, 3'd0, 5'd4));
    send_instr(enc_r(7'h01, 5'd1, 5'd2, 3'd0, 5'd4));      // bad funct7 on ADD
    send_instr(enc_r(7'h7F, 5'd2, 5'd1, 3'd1, 5'd5));      // SLL ignores funct7
    send_instr(enc_r(F7_ZERO, 5'd1, 5'd2, 3'd2, 5'd6));
    send_instr(enc_r(F7_ZERO, 5'd1, 5'd2, 3'd3, 5'd7));
    send_instr(enc_r(F7_ZERO, 5'd1, 5'd2, 3'd4, 5'd8));
    send_instr(enc_r(F7_ZERO, 5'd2, 5'd1, 3'd5, 5'd9));
    send_instr(enc_r(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd10));
    send_instr(enc_r(F7_ZERO, 5'd1, 5'd2, 3'd6, 5'd11));
    send_instr(enc_r(F7_ZERO, 5'd1, 5'd2, 3'd7, 5'd12));
    send_instr(enc_s(12'hFFF, 5'd1, 5'd0, 3'd2));          // word wraps past the top
    send_instr(enc_s(12'h7FF, 5'd2, 5'd0, 3'd1));
    send_instr(enc_s(12'h000, 5'd2, 5'd0, 3'd7));          // bad store width
    send_instr(enc_i(12'hFFF, 5'd0, 3'd2, 5'd13, OP_LOAD));
    send_instr(enc_i(12'hFFF, 5'd0, 3'd0, 5'd14, OP_LOAD));
    send_instr(enc_i(12'h000, 5'd0, 3'd1, 5'd15, OP_LOAD));
    send_instr(enc_i(12'h7FF, 5'd0, 3'd5, 5'd0, OP_LOAD)); // load to x0
    send_instr(enc_i(12'h000, 5'd0, 3'd3, 5'd16, OP_LOAD));
    send_instr(enc_b(13'h1FFC, 5'd1, 5'd2, 3'd4));
    send_instr(enc_b(13'h0010, 5'd1, 5'd2, 3'd2));         // bad branch condition
    send_instr(enc_j(21'h1FFFF6, 5'd1));
    send_instr(enc_i(12'h7FF, 5'd2, 3'd5, 5'd17, OP_JALR)); // odd offset
    send_instr({20'h80000, 5'd18, OP_AUIPC});
    send_instr(enc_i(12'h003, 5'd2, 3'd1, 5'd19, OP_IMM)); // immediate shift
    send_instr(32'h0000_000F);
    send_instr(32'h0000_0073);

    // Random part across several start addresses, the extremes among them.
    load_start(32'hFFFF_FFFC);
    repeat (180) send_instr(random_instr());
    // The sender pauses here until every result has come back.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    load_start(32'hFFFF_FFFF);
    repeat (180) send_instr(random_instr());
    load_start($urandom);
    repeat (190) send_instr(random_instr());
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("rv32i_decode_execute_top_test: PASS");
    end else begin
      $display("rv32i_decode_execute_top_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/rvde_pkg.sv
sv/rvde_ram.sv
sv/rvde_alu.sv
sv/rvde_outq.sv
sv/rv32i_decode_execute_top.sv
dv/rv32i_decode_execute_checker.sv
dv/rv32i_decode_execute_top_test.sv
